// ===== hdl/scp_pkg.sv =====
// Shared character codes and a hex decode helper for the serial command parser.
package scp_pkg;

  localparam logic [7:0] CH_C  = 8'h43;  // 'C'
  localparam logic [7:0] CH_P  = 8'h50;  // 'P'
  localparam logic [7:0] CH_D  = 8'h44;  // 'D'
  localparam logic [7:0] CH_EQ = 8'h3D;  // '='
  localparam logic [7:0] CH_CR = 8'h0D;  // carriage return
  localparam logic [7:0] CH_0  = 8'h30;  // '0'
  localparam logic [7:0] CH_2  = 8'h32;  // '2'
  localparam logic [7:0] CH_9  = 8'h39;  // '9'
  localparam logic [7:0] CH_A  = 8'h41;  // 'A'
  localparam logic [7:0] CH_F  = 8'h46;  // 'F'

  localparam logic [3:0] REG_MAX  = 4'd9;
  localparam logic [1:0] PAGE_MAX = 2'd2;

  typedef struct packed {
    logic       hit;
    logic [3:0] nib;
  } hex_t;

  // Uppercase hex digit decode; lowercase is not a digit.
  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t       r;
    logic [7:0] t;
    r = '0;
    t = '0;
    if (b >= CH_0 && b <= CH_9) begin
      t     = b - CH_0;
      r.hit = 1'b1;
      r.nib = t[3:0];
    end else if (b >= CH_A && b <= CH_F) begin
      t     = b - CH_A + 8'd10;
      r.hit = 1'b1;
      r.nib = t[3:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/serial_command_parser.sv =====
// Serial command parser: byte-stream decoder with staged, committed outputs.
//
// Input channel: one received ASCII byte per item (rx_byte_i), valid/ready.
// Output channel: one item per committing CR, carrying target register,
// write value, sticky write request, display bit and page, valid/ready.
// Commands: "C<0-9>=<1-2 hex>CR", "P<0-2>CR", "D" CR. Any unexpected byte
// sends the parser back to idle; staged values are kept.
// Throughput: one byte per cycle unless a result is stalled. Each byte is decoded
// in the cycle it is accepted against the parser state register; a CR loads the
// result register, so a result appears in the cycle after its CR is accepted.
// The single result register sets the stall behavior: while it holds an
// item the receiver has not taken, in_ready_o follows out_ready_i, so input
// keeps flowing whenever the result is taken in the same cycle.
// Reset clears the parser state, all staged values and the committed
// display bit, and empties the result register. A stalled result holds.
module serial_command_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] target_register_o,
  output logic [7:0] write_value_o,
  output logic       write_request_o,
  output logic       display_on_o,
  output logic [1:0] page_select_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_PAGE  = 3'd1,
    ST_ADDR  = 3'd2,
    ST_EQ    = 3'd3,
    ST_VAL1  = 3'd4,
    ST_VAL2  = 3'd5,
    ST_ENTER = 3'd6
  } state_e;

  state_e       state_q, state_d;
  logic [3:0]   stg_reg_q, stg_reg_d;
  logic [7:0]   stg_val_q, stg_val_d;
  logic         stg_wr_q, stg_wr_d;
  logic         stg_disp_q, stg_disp_d;
  logic [1:0]   stg_page_q, stg_page_d;
  logic         com_disp_q, com_disp_d;
  logic         out_valid_q, out_valid_d;
  logic         commit;
  logic         in_fire;
  logic [7:0]   sub;
  scp_pkg::hex_t hx;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign hx         = scp_pkg::hex_decode(rx_byte_i);
  assign sub        = rx_byte_i - scp_pkg::CH_0;

  always_comb begin
    state_d    = state_q;
    stg_reg_d  = stg_reg_q;
    stg_val_d  = stg_val_q;
    stg_wr_d   = stg_wr_q;
    stg_disp_d = stg_disp_q;
    stg_page_d = stg_page_q;
    com_disp_d = com_disp_q;
    commit     = 1'b0;
    if (in_fire) begin
      state_d = ST_IDLE;
      case (state_q)
        ST_PAGE: begin
          if (rx_byte_i >= scp_pkg::CH_0 && rx_byte_i <= scp_pkg::CH_2) begin
            stg_page_d = sub[1:0];
            state_d    = ST_ENTER;
          end
        end
        ST_ADDR: begin
          if (rx_byte_i >= scp_pkg::CH_0 && rx_byte_i <= scp_pkg::CH_9) begin
            stg_reg_d = sub[3:0];
            state_d   = ST_EQ;
          end
        end
        ST_EQ: begin
          if (rx_byte_i == scp_pkg::CH_EQ) state_d = ST_VAL1;
        end
        ST_VAL1: begin
          if (hx.hit) begin
            stg_val_d = {4'h0, hx.nib};
            stg_wr_d  = 1'b1;
            state_d   = ST_VAL2;
          end
        end
        ST_VAL2: begin
          if (rx_byte_i == scp_pkg::CH_CR) begin
            commit = 1'b1;
          end else if (hx.hit) begin
            stg_val_d = {stg_val_q[3:0], hx.nib};
            stg_wr_d  = 1'b1;
            state_d   = ST_ENTER;
          end
        end
        ST_ENTER: begin
          if (rx_byte_i == scp_pkg::CH_CR) commit = 1'b1;
        end
        default: begin
          if (rx_byte_i == scp_pkg::CH_C) begin
            state_d = ST_ADDR;
          end else if (rx_byte_i == scp_pkg::CH_P) begin
            state_d = ST_PAGE;
          end else if (rx_byte_i == scp_pkg::CH_D) begin
            // toggle is staged now and survives an abandoned command
            stg_disp_d = !com_disp_q;
            state_d    = ST_ENTER;
          end
        end
      endcase
      if (commit) com_disp_d = stg_disp_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stg_reg_q   <= '0;
      stg_val_q   <= '0;
      stg_wr_q    <= 1'b0;
      stg_disp_q  <= 1'b0;
      stg_page_q  <= '0;
      com_disp_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stg_reg_q   <= stg_reg_d;
      stg_val_q   <= stg_val_d;
      stg_wr_q    <= stg_wr_d;
      stg_disp_q  <= stg_disp_d;
      stg_page_q  <= stg_page_d;
      com_disp_q  <= com_disp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded on a committing CR
  always_ff @(posedge clk_i) begin
    if (commit) begin
      target_register_o <= stg_reg_q;
      write_value_o     <= stg_val_q;
      write_request_o   <= stg_wr_q;
      display_on_o      <= stg_disp_q;
      page_select_o     <= stg_page_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/scp_checker.sv =====
// Port-level checker for the serial command parser, bound to serial_command_parser.
module scp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [3:0] target_register_o,
  input logic [7:0] write_value_o,
  input logic       write_request_o,
  input logic       display_on_o,
  input logic [1:0] page_select_o
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(target_register_o)
      && $stable(write_value_o) && $stable(write_request_o)
      && $stable(display_on_o) && $stable(page_select_o))
    else $error("stalled result changed");

  // input only stalls behind an untaken result
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a pending result");

  // a result only follows an accepted item
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("result without an accepted item");

  a_page_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> page_select_o <= scp_pkg::PAGE_MAX)
    else $error("page out of range");

  a_reg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> target_register_o <= scp_pkg::REG_MAX)
    else $error("register address out of range");

endmodule

bind serial_command_parser scp_checker u_scp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .target_register_o (target_register_o),
  .write_value_o     (write_value_o),
  .write_request_o   (write_request_o),
  .display_on_o      (display_on_o),
  .page_select_o     (page_select_o)
);
